// ===== sv/hee_pkg.sv =====
// Package for the HTML entity escaper: item structs, command format and
// the entity spelling table. No dependencies.
package hee_pkg;

	localparam logic [15:0] CAP_RESET   = 16'd256;
	localparam logic [2:0]  GUARD_BYTES = 3'd7;
	localparam logic [7:0]  PRINT_MIN   = 8'h20;
	localparam int          QDEPTH      = 4;
	localparam int          QPTR_W      = 2;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_CHAR = 3'd1,
		KIND_LT   = 3'd2,
		KIND_GT   = 3'd3,
		KIND_AMP  = 3'd4,
		KIND_QUOT = 3'd5,
		KIND_APOS = 3'd6
	} kind_t;

	// one queued request for the back end: an entity or plain byte, plus terminator
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       term;
	} cmd_t;

	function automatic logic [2:0] ent_len(input kind_t kind);
		logic [2:0] len;
		len = 3'd0;
		unique case (kind)
			KIND_NONE: len = 3'd0;
			KIND_CHAR: len = 3'd1;
			KIND_LT, KIND_GT: len = 3'd4;
			KIND_AMP, KIND_APOS: len = 3'd5;
			KIND_QUOT: len = 3'd6;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] ent_byte(input kind_t kind, input logic [2:0] pos,
		input logic [7:0] ch);
		logic [7:0] b;
		b = 8'h00;
		if (pos == 3'd0 && kind != KIND_CHAR) begin
			b = "&";
		end else begin
			unique case (kind)
				KIND_CHAR: b = ch;
				KIND_LT: begin
					case (pos)
						3'd1: b = "l";
						3'd2: b = "t";
						default: b = ";";
					endcase
				end
				KIND_GT: begin
					case (pos)
						3'd1: b = "g";
						3'd2: b = "t";
						default: b = ";";
					endcase
				end
				KIND_AMP: begin
					case (pos)
						3'd1: b = "a";
						3'd2: b = "m";
						3'd3: b = "p";
						default: b = ";";
					endcase
				end
				KIND_QUOT: begin
					case (pos)
						3'd1: b = "q";
						3'd2: b = "u";
						3'd3: b = "o";
						3'd4: b = "t";
						default: b = ";";
					endcase
				end
				KIND_APOS: begin
					case (pos)
						3'd1: b = "#";
						3'd2: b = "3";
						3'd3: b = "9";
						default: b = ";";
					endcase
				end
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

// ===== sv/hee_front.sv =====
// Front end of the escaper: accepts text bytes, tracks count and stop state,
// classifies each byte into a back-end request. Depends on hee_pkg.
module hee_front import hee_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_stall,
	input  in_item_t char_item,
	input  logic     cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic     full,
	output logic     push,
	output cmd_t     push_cmd
);

	localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
	localparam int SUM_W = COUNT_BITS + 1;

	logic [15:0]           capacity_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  stopped_q;

	logic             accept;
	logic             is_zero;
	logic             room;
	logic             handle;
	kind_t            cls_kind;
	kind_t            emit_kind;
	logic [SUM_W-1:0] sum;

	assign char_stall = full;
	assign accept     = char_valid && !char_stall;
	assign is_zero    = (char_item.char_in == 8'h00);
	assign room       = (CMP_W'(count_q) + CMP_W'(GUARD_BYTES)) < CMP_W'(capacity_q);
	assign handle     = !stopped_q && !is_zero && room;

	always_comb begin
		case (char_item.char_in)
			"<":  cls_kind = KIND_LT;
			">":  cls_kind = KIND_GT;
			"&":  cls_kind = KIND_AMP;
			"\"": cls_kind = KIND_QUOT;
			"'":  cls_kind = KIND_APOS;
			default: cls_kind = (char_item.char_in >= PRINT_MIN) ? KIND_CHAR : KIND_NONE;
		endcase
	end

	assign emit_kind = handle ? cls_kind : KIND_NONE;
	assign sum       = SUM_W'(count_q) + SUM_W'(ent_len(emit_kind));

	assign push          = accept && (emit_kind != KIND_NONE || char_item.end_of_text);
	assign push_cmd.kind = emit_kind;
	assign push_cmd.ch   = char_item.char_in;
	assign push_cmd.term = char_item.end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (char_item.end_of_text) begin
				count_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (is_zero) begin
					stopped_q <= 1'b1;
				end else if (room) begin
					if (sum[COUNT_BITS]) begin
						// saturate and stop; the entity already queued goes out whole
						count_q   <= '1;
						stopped_q <= 1'b1;
					end else begin
						count_q <= sum[COUNT_BITS-1:0];
					end
				end
			end
		end
	end

endmodule

// ===== sv/hee_cmd_fifo.sv =====
// Short request queue between front and back ends of the escaper.
// Depends on hee_pkg.
module hee_cmd_fifo import hee_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full       = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/hee_back.sv =====
// Back end of the escaper: spells each queued request out one byte per
// cycle into the output register unless it stalls. Depends on hee_pkg.
module hee_back import hee_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      esc_valid,
	input  logic      esc_stall,
	output out_item_t esc_item
);

	logic [2:0] pos_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       advance;
	logic [2:0] len;
	logic [2:0] total;
	logic       final_byte;
	out_item_t  next_item;

	assign len        = ent_len(head.kind);
	assign total      = len + 3'(head.term);
	assign final_byte = (pos_q == total - 3'd1);
	assign advance    = head_valid && (!out_valid_q || !esc_stall);
	assign pop        = advance && final_byte;

	always_comb begin
		if (pos_q < len) begin
			next_item.out_byte = ent_byte(head.kind, pos_q, head.ch);
			next_item.last     = 1'b0;
		end else begin
			next_item.out_byte = 8'h00;
			next_item.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q       <= final_byte ? 3'd0 : pos_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!esc_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_item;
		end
	end

	assign esc_valid = out_valid_q;
	assign esc_item  = out_q;

`ifndef SYNTHESIS
	// a request in progress stays at the queue head until its last byte
	a_pos_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 3'd0 |-> head_valid)
		else $error("byte position set with no request at queue head");

	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> out_q.out_byte == 8'h00)
		else $error("terminator carries a nonzero byte");

	a_pop_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pos_q == 3'd0)
		else $error("byte position not cleared after request retired");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < total)
		else $error("byte position beyond request length");
`endif

endmodule

// ===== sv/html_entity_escaper_top.sv =====
// Top level of the HTML entity escaper: front end, request queue and back end.
// Depends on hee_pkg, hee_front, hee_cmd_fifo, hee_back.
//
// Usage:
//   Input channel char_valid/char_stall/char_item carries one text byte and
//   an end-of-text mark. Output channel esc_valid/esc_stall/esc_item carries
//   escaped bytes; the terminator (zero byte, last=1) ends each string.
//   cfg_we/cfg_wdata writes the output capacity; write it only while idle.
// Path: an accepted request is written into the queue, and the output
//   register then loads its first byte from the queue head, when the queue
//   was empty and the output was not stalled.
// Throughput: one item per cycle while each item yields at most one byte and
//   the output does not stall. An entity keeps the back end busy until all
//   its bytes, and a terminator if any, have gone out, since the output
//   register takes one byte per cycle; the four-entry queue absorbs short
//   bursts and the input stalls only when the queue is full.
// Reset: capacity returns to 256, the byte count and stop flag clear, the
//   queue empties and no output is valid.
// Output stall: the output register holds its byte, the back end pauses,
//   and the front end keeps taking items until the queue fills.
module html_entity_escaper_top import hee_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  in_item_t    char_item,
	output logic        esc_valid,
	input  logic        esc_stall,
	output out_item_t   esc_item,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// requests between front end and queue
	logic push;
	cmd_t push_cmd;
	logic full;

	// queue head seen by the back end
	logic pop;
	logic head_valid;
	cmd_t head;

	// classify bytes, keep the running count, drop bytes past capacity
	hee_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.full       (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// hold requests so the front end runs ahead of multi-byte entities
	hee_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// spell out entities and terminators one byte per cycle, barring output stall
	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.esc_valid  (esc_valid),
		.esc_stall  (esc_stall),
		.esc_item   (esc_item)
	);

endmodule

// ===== bench/html_entity_escaper_top_test.sv =====
// Self-checking testbench for html_entity_escaper_top: escapes text requests
// through a predictor and compares every output byte. Depends on hee_pkg.
module html_entity_escaper_top_test;
	import hee_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HIGH      = 6;
	localparam int CLK_LOW       = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int COUNT_BITS    = 16;
	localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
	// quiet cycles after the last owed byte before the capacity changes
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int QUIET_LIMIT   = 2000;
	localparam int REPORT_MAX    = 10;

	// Escape predictor plus the queue of bytes still owed by the block.
	class escape_scoreboard;
		logic [15:0] capacity;
		logic [15:0] count;
		bit          stopped;
		out_item_t   expected_bytes[$];
		int          mismatches;

		function new();
			capacity = CAP_RESET;
			count = '0;
			stopped = 1'b0;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [15:0] value);
			capacity = value;
		endfunction

		function void note_request(in_item_t req);
			string spelled;
			int    emitted;
			int    sum;
			emitted = 0;
			if (!stopped) begin
				if (req.char_in == 8'h00) begin
					stopped = 1'b1;
				end else if (32'(count) + 32'(GUARD_BYTES) < 32'(capacity)) begin
					spelled = "";
					case (req.char_in)
						"<": spelled = "&lt;";
						">": spelled = "&gt;";
						"&": spelled = "&amp;";
						8'h22: spelled = "&quot;";
						8'h27: spelled = "&#39;";
						default: spelled = "";
					endcase
					if (spelled.len() != 0) begin
						for (int i = 0; i < spelled.len(); i++)
							expected_bytes.push_back(out_item_t'{out_byte: spelled[i], last: 1'b0});
						emitted = spelled.len();
					end else if (req.char_in >= PRINT_MIN) begin
						expected_bytes.push_back(out_item_t'{out_byte: req.char_in, last: 1'b0});
						emitted = 1;
					end
					sum = 32'(count) + emitted;
					if (sum > COUNT_MAX) begin
						count = COUNT_BITS'(COUNT_MAX);
						stopped = 1'b1;
					end else begin
						count = 16'(sum);
					end
				end
			end
			if (req.end_of_text) begin
				expected_bytes.push_back(out_item_t'{out_byte: 8'h00, last: 1'b1});
				count = '0;
				stopped = 1'b0;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected output byte %02h last %0b",
						$realtime, got.out_byte, got.last);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
						$realtime, want.out_byte, want.last, got.out_byte, got.last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	in_item_t    char_item;
	logic        esc_valid;
	logic        esc_stall;
	out_item_t   esc_item;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	escape_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req_cnt  = 0;
	int quiet_cycles  = 0;

	html_entity_escaper_top #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.esc_valid  (esc_valid),
		.esc_stall  (esc_stall),
		.esc_item   (esc_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// Output side: take every byte the block hands over at an edge where we
	// did not stall, and check it against the oldest owed byte.
	always @(posedge clk) begin
		if (arst_n && esc_valid && !esc_stall)
			sb.check_result(esc_item);
	end

	// Receiver stall pattern. A hold request from the stimulus makes us refuse
	// output for a long stretch so the queue fills and the input backs up.
	initial begin
		int hold_served;
		hold_served = 0;
		esc_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req_cnt != hold_served) begin
				hold_served++;
				esc_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			esc_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (esc_valid && !esc_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("html_entity_escaper_top verification failed");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it. Random idle
	// cycles drop valid before the request is raised.
	task automatic push_char(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= in_item_t'{char_in: c, end_of_text: eot};
		@(posedge clk);
		while (char_stall) @(posedge clk);
		sb.note_request(in_item_t'{char_in: c, end_of_text: eot});
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1);
	endtask

	// One string of random length, mostly short; the last byte carries the
	// end mark. Content leans on entity characters and includes control
	// bytes, high bytes and the odd zero that cuts the string short.
	task automatic send_random_string(output int len);
		logic [7:0] c;
		int roll;
		len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				case ($urandom_range(4))
					0: c = "<";
					1: c = ">";
					2: c = "&";
					3: c = 8'h22;
					default: c = 8'h27;
				endcase
			end else if (roll < 40) begin
				c = 8'($urandom_range(1, 31));
			end else if (roll < 42) begin
				c = 8'h00;
			end else if (roll < 52) begin
				c = 8'($urandom_range(128, 255));
			end else begin
				c = 8'($urandom_range(32, 127));
			end
			push_char(c, i == len - 1);
		end
	endtask

	task automatic write_capacity(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
	endtask

	// Drop valid, wait for every owed byte, then let the pipe empty out.
	task automatic settle();
		char_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] cap, input int spct, input int rpct,
		input int n_items, input bit with_hold);
		int sent;
		int len;
		write_capacity(cap);
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		if (with_hold)
			hold_req_cnt <= hold_req_cnt + 1;
		sent = 0;
		while (sent < n_items) begin
			send_random_string(len);
			sent += len;
		end
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_item  = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity, sender mostly active, receiver mostly stalling.
		send_idle_pct = 26;
		recv_idle_pct = 74;
		send_text("<>&\"'");
		// control bytes drop, the printable edges and high bytes pass
		push_char(8'h1F, 1'b0);
		push_char(8'h01, 1'b0);
		push_char(8'h20, 1'b0);
		push_char(8'h7F, 1'b0);
		push_char(8'h80, 1'b0);
		push_char(8'hFF, 1'b1);
		// zero mid-string stops the rest, terminator still comes
		push_char("a", 1'b0);
		push_char(8'h00, 1'b0);
		push_char("b", 1'b0);
		push_char("&", 1'b1);
		// zero byte carrying the end mark
		push_char(8'h00, 1'b1);
		push_char("Z", 1'b1);
		settle();
		// capacity 12: the first entity fits, the rest of the string is cut
		write_capacity(16'd12);
		send_text("x&&y");
		settle();

		// Random phases: receiver sparse first, then sender sparse, then no idling.
		run_phase(16'd256,   26, 74, 60, 1'b0);
		run_phase(16'd12,    26, 74, 60, 1'b0);
		run_phase(16'd65535, 74, 26, 60, 1'b0);
		run_phase(16'd1,     74, 26, 40, 1'b0);
		run_phase(16'd8,     0,  0,  50, 1'b0);
		run_phase(16'd30,    0,  0,  60, 1'b1);
		run_phase(16'd7,     0,  0,  20, 1'b0);
		run_phase(16'd256,   0,  0,  50, 1'b0);

		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
			$display("html_entity_escaper_top verification clean");
		end else begin
			$display("html_entity_escaper_top verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hee_pkg.sv
sv/hee_front.sv
sv/hee_cmd_fifo.sv
sv/hee_back.sv
sv/html_entity_escaper_top.sv
bench/html_entity_escaper_top_test.sv
